// ===== design/lzwe_pkg.sv =====
package lzwe_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CODE_W   = 16;
  localparam int unsigned NFC_W    = 17;
  localparam int unsigned CWID_W   = 5;
  localparam int unsigned DSIZE_W  = 13;
  localparam int unsigned KEY_W    = 24;
  localparam int unsigned ACC_W    = 24;
  localparam int unsigned CIDX_W   = 2;
  localparam int unsigned CDATA_W  = 13;
  localparam int unsigned LANES    = 4;
  localparam int unsigned LANE_W   = 2;

  localparam logic [CIDX_W-1:0] REG_MAX_DICT   = 2'd0;
  localparam logic [CIDX_W-1:0] REG_INIT_WIDTH = 2'd1;

  localparam logic [NFC_W-1:0]  FIRST_CODE = 17'd256;
  localparam logic [CWID_W-1:0] MIN_WIDTH  = 5'd8;
  localparam logic [CWID_W-1:0] MAX_WIDTH  = 5'd16;

  typedef struct packed {
    logic                hit;
    logic [CODE_W-1:0]   code;
  } match_t;

  function automatic logic [CWID_W-1:0] clamp_width(input logic [CWID_W-1:0] w);
    logic [CWID_W-1:0] r;
    if (w < MIN_WIDTH) r = MIN_WIDTH;
    else if (w > MAX_WIDTH) r = MAX_WIDTH;
    else r = w;
    return r;
  endfunction

  // place the masked code above the pending bits
  function automatic logic [ACC_W-1:0] pack_code(input logic [BYTE_W-1:0] buf_bits,
                                                 input logic [2:0] cnt,
                                                 input logic [CODE_W-1:0] code,
                                                 input logic [CWID_W-1:0] cw);
    logic [NFC_W-1:0] mask;
    logic [ACC_W-1:0] c;
    mask = ~({NFC_W{1'b1}} << cw);
    c = {8'd0, code & mask[CODE_W-1:0]};
    return {16'd0, buf_bits} | (c << cnt);
  endfunction

endpackage

// ===== design/lzwe_if.sv =====
interface lzwe_in_if;
  import lzwe_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              in_last;
  modport source (output valid, in_byte, in_last, input ready);
  modport sink   (input valid, in_byte, in_last, output ready);
endinterface

interface lzwe_out_if;
  import lzwe_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              out_last;
  modport source (output valid, out_byte, out_last, input ready);
  modport sink   (input valid, out_byte, out_last, output ready);
endinterface

interface lzwe_cfg_if;
  import lzwe_pkg::*;
  logic               valid;
  logic               ready;
  logic [CIDX_W-1:0]  index;
  logic [CDATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/lzw_stream_encoder_core.sv =====
// LZW stream encoder with variable code width.
// src: one message byte per transfer, in_last marks the final byte.
// dst: packed code bytes, least significant bit first; out_last marks the
//   final byte of a message's output.
// cfg: register writes (index 0 max_dict_size, index 1 initial_code_width),
//   always ready; initial_code_width takes effect at the next message start, max_dict_size at once.
// The dictionary is split over four cells, each owning one RAM bank; a
// lookup reads one row of four entries a cycle and the match ripples down
// the row. At message start a byte only becomes the prefix, and a one-byte
// message emits it as its code. Otherwise the accepted byte starts a search
// over the ceil((next_free_code - 256) / 4) occupied rows; a hit on a byte
// that is not the last ends there, while a miss or the last byte packs its
// codes and emits each completed output byte before the next byte is taken.
// The output register lets the next byte be taken while the last result of
// the previous one waits; while dst stalls the encoder holds in its output state.
// Reset returns to message start with the default registers; dictionary
// contents need no clearing since only entries below next_free_code are read.
module lzw_stream_encoder_core import lzwe_pkg::*; #(
  parameter int unsigned MAX_CODES = 4096
) (
  input logic         clk,
  input logic         rst,
  lzwe_in_if.sink     src,
  lzwe_out_if.source  dst,
  lzwe_cfg_if.sink    cfg
);
  localparam int unsigned ROWS = (MAX_CODES - 256) / LANES;
  localparam int unsigned RW   = $clog2(ROWS);
  localparam logic [NFC_W-1:0] MAX_CODES_V = NFC_W'(MAX_CODES);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SRCH = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0]         state;
  logic [DSIZE_W-1:0] max_dict_size;
  logic [CWID_W-1:0]  init_width;
  logic [CODE_W-1:0]  prefix;
  logic               prefix_valid;
  logic [NFC_W-1:0]   nfc;
  logic [CWID_W-1:0]  code_width;
  logic [BYTE_W-1:0]  bit_buffer;
  logic [2:0]         bit_count;
  logic [BYTE_W-1:0]  cur_byte;
  logic               cur_last;
  logic [RW:0]        rd_row;
  logic [RW-1:0]      cmp_row;
  logic               cmp_valid;
  logic [ACC_W-1:0]   em_acc;
  logic [CWID_W-1:0]  em_cnt;
  logic               em_final;
  logic               pend_final;
  logic               out_valid;
  logic [BYTE_W-1:0]  out_byte;
  logic               out_last;

  logic [NFC_W-1:0]   limit;
  logic [NFC_W-1:0]   nrows;
  logic               issuing;
  logic [NFC_W-1:0]   widx;
  logic               ins_en;
  logic [LANES-1:0]   bank_we;
  logic [KEY_W-1:0]   key;
  logic               push_ok;
  logic [NFC_W-1:0]   nfc_inc;
  logic [CWID_W-1:0]  cw_start;
  match_t             chain [LANES+1];

  assign limit    = ({4'd0, max_dict_size} < MAX_CODES_V) ? {4'd0, max_dict_size}
                                                         : MAX_CODES_V;
  assign nrows    = (nfc - FIRST_CODE + NFC_W'(LANES - 1)) >> LANE_W;
  assign issuing  = NFC_W'(rd_row) < nrows;
  assign widx     = nfc - FIRST_CODE;
  assign key      = {prefix, cur_byte};
  assign push_ok  = !out_valid || dst.ready;
  assign nfc_inc  = nfc + NFC_W'(1);
  assign cw_start = clamp_width(init_width);
  assign chain[0] = '0;

  for (genvar g = 0; g < LANES; g++) begin : g_cell
    assign bank_we[g] = ins_en && (widx[LANE_W-1:0] == LANE_W'(g));
    lzwe_cell #(.BANK(g), .ROWS(ROWS)) u_cell (
      .clk       (clk),
      .we        (bank_we[g]),
      .waddr     (widx[RW+LANE_W-1:LANE_W]),
      .wdata     (key),
      .raddr     (rd_row[RW-1:0]),
      .cmp_row   (cmp_row),
      .key       (key),
      .nfc       (nfc),
      .chain_in  (chain[g]),
      .chain_out (chain[g+1])
    );
  end

  // insert on a miss while the dictionary has room
  assign ins_en = (state == S_SRCH) && !(cmp_valid && chain[LANES].hit) &&
                  !issuing && !cmp_valid && (nfc < limit);

  assign src.ready    = (state == S_IDLE);
  assign cfg.ready    = 1'b1;
  assign dst.valid    = out_valid;
  assign dst.out_byte = out_byte;
  assign dst.out_last = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      max_dict_size <= 13'd4096;
      init_width    <= 5'd9;
      prefix        <= '0;
      prefix_valid  <= 1'b0;
      nfc           <= FIRST_CODE;
      code_width    <= 5'd9;
      bit_buffer    <= '0;
      bit_count     <= '0;
      rd_row        <= '0;
      cmp_valid     <= 1'b0;
      em_final      <= 1'b0;
      pend_final    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          REG_MAX_DICT:   max_dict_size <= cfg.data;
          REG_INIT_WIDTH: init_width    <= cfg.data[CWID_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && dst.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (src.valid) begin
            cur_byte <= src.in_byte;
            cur_last <= src.in_last;
            if (!prefix_valid) begin
              nfc          <= FIRST_CODE;
              code_width   <= cw_start;
              bit_buffer   <= '0;
              bit_count    <= '0;
              prefix       <= {8'd0, src.in_byte};
              prefix_valid <= 1'b1;
              if (src.in_last) begin
                em_acc     <= pack_code('0, 3'd0, {8'd0, src.in_byte}, cw_start);
                em_cnt     <= cw_start;
                em_final   <= 1'b1;
                pend_final <= 1'b0;
                state      <= S_OUT;
              end
            end else begin
              rd_row    <= '0;
              cmp_valid <= 1'b0;
              state     <= S_SRCH;
            end
          end
        end
        S_SRCH: begin
          cmp_valid <= issuing;
          cmp_row   <= rd_row[RW-1:0];
          if (issuing) begin
            rd_row <= rd_row + (RW+1)'(1);
          end
          if (cmp_valid && chain[LANES].hit) begin
            prefix <= chain[LANES].code;
            if (cur_last) begin
              em_acc     <= pack_code(bit_buffer, bit_count, chain[LANES].code, code_width);
              em_cnt     <= CWID_W'(bit_count) + code_width;
              em_final   <= 1'b1;
              pend_final <= 1'b0;
              state      <= S_OUT;
            end else begin
              state <= S_IDLE;
            end
          end else if (!issuing && !cmp_valid) begin
            em_acc     <= pack_code(bit_buffer, bit_count, prefix, code_width);
            em_cnt     <= CWID_W'(bit_count) + code_width;
            em_final   <= 1'b0;
            pend_final <= cur_last;
            prefix     <= {8'd0, cur_byte};
            if (ins_en) begin
              nfc <= nfc_inc;
              if ({1'b0, nfc_inc} > (18'd1 << code_width) && code_width < MAX_WIDTH) begin
                code_width <= code_width + CWID_W'(1);
              end
            end
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (em_cnt >= CWID_W'(8)) begin
            if (push_ok) begin
              out_valid <= 1'b1;
              out_byte  <= em_acc[BYTE_W-1:0];
              out_last  <= em_final && (em_cnt == CWID_W'(8));
              em_acc    <= em_acc >> BYTE_W;
              em_cnt    <= em_cnt - CWID_W'(8);
            end
          end else if (em_final) begin
            if (em_cnt == '0 || push_ok) begin
              if (em_cnt != '0) begin
                out_valid <= 1'b1;
                out_byte  <= em_acc[BYTE_W-1:0];
                out_last  <= 1'b1;
              end
              prefix_valid <= 1'b0;
              bit_buffer   <= '0;
              bit_count    <= '0;
              em_final     <= 1'b0;
              state        <= S_IDLE;
            end
          end else if (pend_final) begin
            em_acc     <= pack_code(em_acc[BYTE_W-1:0], em_cnt[2:0], prefix, code_width);
            em_cnt     <= CWID_W'(em_cnt[2:0]) + code_width;
            em_final   <= 1'b1;
            pend_final <= 1'b0;
          end else begin
            bit_buffer <= em_acc[BYTE_W-1:0];
            bit_count  <= em_cnt[2:0];
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== design/lzwe_ram.sv =====
module lzwe_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 960
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== design/lzwe_cell.sv =====
module lzwe_cell import lzwe_pkg::*; #(
  parameter int unsigned BANK = 0,
  parameter int unsigned ROWS = 960
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [$clog2(ROWS)-1:0] waddr,
  input  logic [KEY_W-1:0]        wdata,
  input  logic [$clog2(ROWS)-1:0] raddr,
  input  logic [$clog2(ROWS)-1:0] cmp_row,
  input  logic [KEY_W-1:0]        key,
  input  logic [NFC_W-1:0]        nfc,
  input  match_t                  chain_in,
  output match_t                  chain_out
);
  logic [KEY_W-1:0] rdata;
  logic [NFC_W-1:0] my_code;

  lzwe_ram #(.WIDTH(KEY_W), .DEPTH(ROWS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign my_code = FIRST_CODE + NFC_W'({cmp_row, LANE_W'(BANK)});

  // earlier lane wins: pass an upstream hit through unchanged
  always_comb begin
    chain_out = chain_in;
    if (!chain_in.hit && my_code < nfc && rdata == key) begin
      chain_out.hit  = 1'b1;
      chain_out.code = my_code[CODE_W-1:0];
    end
  end
endmodule

// ===== design/lzwe_checker.sv =====
module lzwe_checker import lzwe_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [BYTE_W-1:0] out_byte,
  input logic              out_last
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output valid dropped before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_byte) && $stable(out_last))
    else $error("output payload changed while stalled");

  a_rst_idle: assert property (@(posedge clk) rst |=> in_ready)
    else $error("input not ready after reset");

  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");
endmodule

bind lzw_stream_encoder_core lzwe_checker u_lzwe_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (src.ready),
  .out_valid (dst.valid),
  .out_ready (dst.ready),
  .out_byte  (dst.out_byte),
  .out_last  (dst.out_last)
);

// ===== verif/lzwe_tb_if.sv =====
`timescale 1ns / 100ps
// Interfaces are provided by design/lzwe_if.sv; this file holds the
// message-byte and register-write types used by the testbench top.
package lzwe_tb_pkg;
  import lzwe_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } msg_byte_t;

  typedef struct packed {
    logic [CIDX_W-1:0]  index;
    logic [CDATA_W-1:0] data;
  } reg_write_t;
endpackage

// ===== verif/lzw_stream_encoder_core_tb.sv =====
`timescale 1ns / 100ps
module lzw_stream_encoder_core_tb;
  import lzwe_pkg::*;
  import lzwe_tb_pkg::*;

  localparam int DEPTH = 4096;
  localparam int LIMIT = 3000000;

  logic clk;
  logic rst;
  lzwe_in_if  src ();
  lzwe_out_if dst ();
  lzwe_cfg_if cfg ();

  lzw_stream_encoder_core #(.MAX_CODES(DEPTH)) uut (
    .clk(clk), .rst(rst), .src(src.sink), .dst(dst.source), .cfg(cfg.sink)
  );

  always begin
    clk = 1'b0; #2;
    clk = 1'b1; #2;
  end

  // predictor state
  int unsigned dict_limit_reg, width_reg;
  int unsigned pfx, nfc, cwid, bbuf, bcnt;
  bit          pfx_ok;
  int unsigned dict_key [0:DEPTH-1];
  msg_byte_t   expected_bytes [$];

  msg_byte_t   pending_bytes [$];
  reg_write_t  pending_writes [$];
  int          errors, cycles, outs_seen, msgs_sent;
  bit          src_idle_ok, dst_idle_ok;
  int          src_gap, dst_gap;

  function automatic int unsigned clampw(int unsigned w);
    if (w < MIN_WIDTH) return MIN_WIDTH;
    if (w > MAX_WIDTH) return MAX_WIDTH;
    return w;
  endfunction

  function automatic void restart_message();
    pfx = 0; pfx_ok = 0; nfc = FIRST_CODE;
    cwid = clampw(width_reg); bbuf = 0; bcnt = 0;
  endfunction

  function automatic void pack_bits(int unsigned code);
    int unsigned acc, cnt;
    msg_byte_t   o;
    acc = (bbuf & 8'hFF) | ((code & ((32'd1 << cwid) - 1)) << bcnt);
    cnt = bcnt + cwid;
    while (cnt >= 8) begin
      o.data = acc[7:0]; o.last = 1'b0;
      expected_bytes.push_back(o);
      acc >>= 8; cnt -= 8;
    end
    bbuf = acc & 8'hFF; bcnt = cnt;
  endfunction

  function automatic void encode_byte(msg_byte_t in);
    int unsigned lim, key, c, n0;
    bit          hit;
    msg_byte_t   o;
    lim = (dict_limit_reg < DEPTH) ? dict_limit_reg : DEPTH;
    n0 = expected_bytes.size();
    if (!pfx_ok) begin
      restart_message();
      pfx = in.data; pfx_ok = 1;
    end else begin
      key = ((pfx & 16'hFFFF) << 8) | in.data;
      hit = 0;
      for (c = FIRST_CODE; c < nfc && c < DEPTH; c++)
        if (!hit && dict_key[c] == key) begin
          hit = 1; pfx = c;
        end
      if (!hit) begin
        pack_bits(pfx);
        if (nfc < lim) begin
          dict_key[nfc] = key;
          nfc++;
          if (nfc > (32'd1 << cwid) && cwid < 16) cwid++;
        end
        pfx = in.data;
      end
    end
    if (in.last) begin
      pack_bits(pfx);
      if (bcnt > 0) begin
        o.data = bbuf[7:0]; o.last = 1'b0;
        expected_bytes.push_back(o);
      end
      if (expected_bytes.size() > n0) expected_bytes[$].last = 1'b1;
      restart_message();
    end
  endfunction

  // driver: source side
  always @(posedge clk) begin
    if (rst) begin
      src.valid <= 1'b0;
    end else begin
      if (src.valid && src.ready) begin
        encode_byte(pending_bytes.pop_front());
        msgs_sent += 0;
      end
      if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        src.valid <= 1'b0;
      end else if ((src.valid && src.ready ? pending_bytes.size() > 0
                    : pending_bytes.size() > 0)) begin
        if (src_idle_ok && !(src.valid && !src.ready) && $urandom_range(0, 7) == 0) begin
          src_gap <= $urandom_range(1, 4) - 1;
          src.valid <= 1'b0;
        end else begin
          src.valid   <= 1'b1;
          src.in_byte <= pending_bytes[0].data;
          src.in_last <= pending_bytes[0].last;
        end
      end else begin
        src.valid <= 1'b0;
      end
    end
  end

  // sink side: backpressure and checking
  always @(posedge clk) begin
    msg_byte_t e;
    if (rst) begin
      dst.ready <= 1'b0;
    end else begin
      if (dst.valid && dst.ready) begin
        outs_seen++;
        if (expected_bytes.size() == 0) begin
          errors++;
          $display("%0t: unexpected output byte %h last %b", $time,
                   dst.out_byte, dst.out_last);
        end else begin
          e = expected_bytes.pop_front();
          if (e.data !== dst.out_byte) begin
            errors++;
            $display("%0t: out_byte expected %h actual %h", $time, e.data, dst.out_byte);
          end
          if (e.last !== dst.out_last) begin
            errors++;
            $display("%0t: out_last expected %b actual %b", $time, e.last, dst.out_last);
          end
        end
      end
      if (dst_gap > 0) begin
        dst_gap <= dst_gap - 1;
        dst.ready <= 1'b0;
      end else if (dst_idle_ok && $urandom_range(0, 5) == 0) begin
        dst_gap <= $urandom_range(1, 4) - 1;
        dst.ready <= 1'b0;
      end else begin
        dst.ready <= 1'b1;
      end
    end
  end

  // config channel, only fed while idle
  always @(posedge clk) begin
    if (rst) begin
      cfg.valid <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == REG_MAX_DICT) dict_limit_reg = cfg.data;
        else if (cfg.index == REG_INIT_WIDTH) width_reg = cfg.data[4:0];
        void'(pending_writes.pop_front());
      end
      if (pending_writes.size() > 0) begin
        cfg.valid <= 1'b1;
        cfg.index <= pending_writes[0].index;
        cfg.data  <= pending_writes[0].data;
      end else begin
        cfg.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("lzw_stream_encoder_core_tb: errors");
      $finish;
    end
  end

  task automatic add_message(int len, int alpha);
    msg_byte_t b;
    for (int i = 0; i < len; i++) begin
      b.data = (alpha >= 256) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, alpha - 1));
      b.last = (i == len - 1);
      pending_bytes.push_back(b);
    end
    msgs_sent++;
  endtask

  task automatic add_fixed(int unsigned v, bit l);
    msg_byte_t b;
    b.data = 8'(v); b.last = l;
    pending_bytes.push_back(b);
  endtask

  task automatic wait_drained();
    wait (pending_bytes.size() == 0 && !src.valid);
    wait (expected_bytes.size() == 0);
    // a byte with no output may still be searching the dictionary
    repeat (1200) @(posedge clk);
  endtask

  task automatic set_regs(int unsigned dsz, int unsigned w);
    reg_write_t r;
    r.index = REG_MAX_DICT;   r.data = CDATA_W'(dsz); pending_writes.push_back(r);
    r.index = REG_INIT_WIDTH; r.data = CDATA_W'(w);   pending_writes.push_back(r);
    r.index = 2'd3;           r.data = CDATA_W'($urandom); pending_writes.push_back(r);
    wait (pending_writes.size() == 0);
    @(posedge clk);
  endtask

  initial begin
    int unsigned sizes [6] = '{4096, 256, 300, 8191, 0, 1000};
    int unsigned widths[6] = '{9, 8, 16, 31, 0, 12};
    src.valid = 0; src.in_byte = 0; src.in_last = 0;
    dst.ready = 0; cfg.valid = 0; cfg.index = 0; cfg.data = 0;
    dict_limit_reg = 4096; width_reg = 9; restart_message(); cwid = 9;
    errors = 0; cycles = 0; outs_seen = 0; msgs_sent = 0;
    src_gap = 0; dst_gap = 0; src_idle_ok = 0; dst_idle_ok = 0;
    rst = 1;
    repeat (3) @(posedge clk);
    rst <= 0;
    // directed: extremes, single byte, repeats
    add_fixed(8'h00, 1); add_fixed(8'hFF, 1);
    for (int i = 0; i < 8; i++) add_fixed(8'h41, i == 7);
    add_fixed(8'hFF, 0); add_fixed(8'h00, 0); add_fixed(8'hFF, 0);
    add_fixed(8'h00, 0); add_fixed(8'hAA, 0); add_fixed(8'h55, 1);
    wait_drained();
    src_idle_ok = 1; dst_idle_ok = 1;
    for (int p = 0; p < 6; p++) begin
      set_regs(sizes[p], widths[p]);
      add_fixed(8'h7E, 1);
      for (int m = 0; m < 3; m++) add_message($urandom_range(3, 24),
                                               (m == 0) ? 256 : $urandom_range(2, 4));
      if (p == 5) begin
        src_idle_ok = 0; dst_idle_ok = 0;
      end
      wait_drained();
    end
    $display("Covered %0d messages, %0d output bytes, six register settings.",
             msgs_sent, outs_seen);
    if (errors == 0)
      $display("lzw_stream_encoder_core_tb: clean");
    else
      $display("lzw_stream_encoder_core_tb: errors");
    $finish;
  end
endmodule

// ===== lzw_stream_encoder_core.f =====
design/lzwe_pkg.sv
design/lzwe_if.sv
design/lzwe_ram.sv
design/lzwe_cell.sv
design/lzw_stream_encoder_core.sv
design/lzwe_checker.sv
verif/lzwe_tb_if.sv
verif/lzw_stream_encoder_core_tb.sv
